@@ design/bmhq_pkg.sv @@
// Shared types and codes for the binary max-heap priority queue.
package bmhq_pkg;

    // Operation codes on the action input
    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_REMOVE = 1'b1;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_UP_CHK,
        S_UP_CMP,
        S_DN_CAP,
        S_DN_CHK,
        S_DN_CMP
    } state_t;

    // Read address selection for the two read ports
    typedef enum logic [1:0] {
        RD_NONE,
        RD_PARENT,
        RD_CHILDREN,
        RD_ROOT_LAST
    } rd_sel_t;

    // Write data selection, write address is always the current hole
    typedef enum logic [1:0] {
        WR_NONE,
        WR_KEY,
        WR_PARENT,
        WR_PICK
    } wr_sel_t;

    // Controller to datapath commands
    typedef struct packed {
        logic    load_ins;
        logic    load_rem;
        logic    cap_rem;
        rd_sel_t rd_sel;
        wr_sel_t wr_sel;
        logic    finish;
        status_t res_status;
        logic    res_remove;
    } bmhq_cmd_t;

    // Datapath to controller status flags
    typedef struct packed {
        logic full;
        logic empty;
        logic pos_zero;
        logic left_out;
        logic parent_less;
        logic child_gt;
    } bmhq_flags_t;

endpackage

@@ design/bmhq_ctrl.sv @@
// Controller state machine sequencing sift-up and sift-down steps.
module bmhq_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 action,
    input  bmhq_pkg::bmhq_flags_t flags,
    output bmhq_pkg::bmhq_cmd_t  cmd,
    output logic                 busy
);
    import bmhq_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    // Next state and command decode
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.rd_sel = RD_NONE;
        cmd.wr_sel = WR_NONE;
        cmd.res_status = ST_OK;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (action == ACT_INSERT)
                    begin
                        if (flags.full)
                        begin
                            cmd.finish     = 1'b1;
                            cmd.res_status = ST_FULL;
                        end
                        else
                        begin
                            cmd.load_ins = 1'b1;
                            state_next   = S_UP_CHK;
                        end
                    end
                    else
                    begin
                        if (flags.empty)
                        begin
                            cmd.finish     = 1'b1;
                            cmd.res_status = ST_EMPTY;
                            cmd.res_remove = 1'b1;
                        end
                        else
                        begin
                            cmd.load_rem = 1'b1;
                            cmd.rd_sel   = RD_ROOT_LAST;
                            state_next   = S_DN_CAP;
                        end
                    end
                end
            end
            // hole at root: drop the key in, else fetch parent
            S_UP_CHK:
            begin
                if (flags.pos_zero)
                begin
                    cmd.wr_sel = WR_KEY;
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.rd_sel = RD_PARENT;
                    state_next = S_UP_CMP;
                end
            end
            // smaller parent moves down into the hole
            S_UP_CMP:
            begin
                if (flags.parent_less)
                begin
                    cmd.wr_sel = WR_PARENT;
                    state_next = S_UP_CHK;
                end
                else
                begin
                    cmd.wr_sel = WR_KEY;
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            // root and last entry arrive from memory
            S_DN_CAP:
            begin
                cmd.cap_rem = 1'b1;
                state_next  = S_DN_CHK;
            end
            S_DN_CHK:
            begin
                if (flags.left_out)
                begin
                    cmd.wr_sel     = WR_KEY;
                    cmd.finish     = 1'b1;
                    cmd.res_remove = 1'b1;
                    state_next     = S_IDLE;
                end
                else
                begin
                    cmd.rd_sel = RD_CHILDREN;
                    state_next = S_DN_CMP;
                end
            end
            // larger child moves up into the hole
            S_DN_CMP:
            begin
                if (flags.child_gt)
                begin
                    cmd.wr_sel = WR_PICK;
                    state_next = S_DN_CHK;
                end
                else
                begin
                    cmd.wr_sel     = WR_KEY;
                    cmd.finish     = 1'b1;
                    cmd.res_remove = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

@@ design/bmhq_dp.sv @@
// Datapath: heap memory, hole position, moving key, size and result registers.
module bmhq_dp #(
    parameter int CAPACITY = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic signed [31:0]    value,
    input  bmhq_pkg::bmhq_cmd_t   cmd,
    output bmhq_pkg::bmhq_flags_t flags,
    output logic                  done,
    output logic [1:0]            status,
    output logic signed [31:0]    removed_value,
    output logic [5:0]            entry_count
);
    import bmhq_pkg::*;

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic signed [31:0] mem [CAPACITY];

    logic [CNT_W-1:0]   size_reg;
    logic [CNT_W-1:0]   size_next;
    logic [IDX_W-1:0]   pos_reg;
    logic [IDX_W-1:0]   pos_next;
    logic signed [31:0] key_reg;
    logic signed [31:0] key_next;
    logic signed [31:0] rem_reg;
    logic signed [31:0] rem_next;
    logic signed [31:0] rd_a_reg;
    logic signed [31:0] rd_b_reg;
    logic               done_reg;
    logic [1:0]         status_reg;
    logic signed [31:0] out_val_reg;
    logic [5:0]         count_reg;

    logic [IDX_W-1:0]   parent_idx;
    logic [IDX_W:0]     left_full;
    logic [IDX_W+1:0]   right_full;
    logic [IDX_W-1:0]   left_idx;
    logic [IDX_W-1:0]   right_idx;
    logic               right_in;
    logic               pick_right;
    logic signed [31:0] pick_val;
    logic [IDX_W-1:0]   rd_addr_a;
    logic [IDX_W-1:0]   rd_addr_b;
    logic               wr_en;
    logic signed [31:0] wr_data;

    // Tree index arithmetic around the hole
    assign parent_idx = IDX_W'((pos_reg - 1'b1) >> 1);
    assign left_full  = {pos_reg, 1'b1};
    assign right_full = (IDX_W+2)'(left_full) + 1'b1;
    assign left_idx   = left_full[IDX_W-1:0];
    assign right_idx  = right_full[IDX_W-1:0];
    assign right_in   = (right_full < (IDX_W+2)'(size_reg));
    assign pick_right = right_in && (rd_a_reg < rd_b_reg);
    assign pick_val   = pick_right ? rd_b_reg : rd_a_reg;

    // Status flags for the controller
    assign flags.full        = (size_reg == CNT_W'(CAPACITY));
    assign flags.empty       = (size_reg == '0);
    assign flags.pos_zero    = (pos_reg == '0);
    assign flags.left_out    = ((IDX_W+2)'(left_full) >= (IDX_W+2)'(size_reg));
    assign flags.parent_less = (rd_a_reg < key_reg);
    assign flags.child_gt    = (key_reg < pick_val);

    // Read address selection
    always_comb
    begin
        rd_addr_a = parent_idx;
        rd_addr_b = parent_idx;
        case (cmd.rd_sel)
            RD_PARENT:
            begin
                rd_addr_a = parent_idx;
            end
            RD_CHILDREN:
            begin
                rd_addr_a = left_idx;
                rd_addr_b = right_idx;
            end
            RD_ROOT_LAST:
            begin
                rd_addr_a = '0;
                rd_addr_b = IDX_W'(size_reg - 1'b1);
            end
            default:
            begin
                rd_addr_a = parent_idx;
            end
        endcase
    end

    // Write data selection and hole movement
    always_comb
    begin
        wr_en    = 1'b1;
        wr_data  = key_reg;
        pos_next = pos_reg;
        case (cmd.wr_sel)
            WR_KEY:
            begin
                wr_data = key_reg;
            end
            WR_PARENT:
            begin
                wr_data  = rd_a_reg;
                pos_next = parent_idx;
            end
            WR_PICK:
            begin
                wr_data  = pick_val;
                pos_next = pick_right ? right_idx : left_idx;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
        if (cmd.load_ins)
        begin
            pos_next = IDX_W'(size_reg);
        end
        else if (cmd.load_rem)
        begin
            pos_next = '0;
        end
    end

    // Size, key and removed-value updates
    always_comb
    begin
        size_next = size_reg;
        key_next  = key_reg;
        rem_next  = rem_reg;
        if (cmd.load_ins)
        begin
            size_next = size_reg + 1'b1;
            key_next  = value;
        end
        if (cmd.load_rem)
        begin
            size_next = size_reg - 1'b1;
        end
        if (cmd.cap_rem)
        begin
            rem_next = rd_a_reg;
            key_next = rd_b_reg;
        end
    end

    // Heap memory with registered read ports
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[pos_reg] <= wr_data;
        end
        rd_a_reg <= mem[rd_addr_a];
        rd_b_reg <= mem[rd_addr_b];
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        pos_reg <= pos_next;
        key_reg <= key_next;
        rem_reg <= rem_next;
        if (cmd.finish)
        begin
            status_reg  <= cmd.res_status;
            out_val_reg <= (cmd.res_remove && cmd.res_status == ST_OK) ? rem_reg : '0;
            count_reg   <= 6'(size_reg);
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            size_reg <= size_next;
            done_reg <= cmd.finish;
        end
    end

    assign done          = done_reg;
    assign status        = status_reg;
    assign removed_value = out_val_reg;
    assign entry_count   = count_reg;

endmodule

@@ design/binary_max_heap_queue.sv @@
// Binary max-heap priority queue: sequential sift up/down over a heap memory.
// An insert steps through a check and a compare state per level moved; a remove first
// captures the root and the last entry, then checks and compares per level. An entry moves
// at most log2(CAPACITY) levels. A full insert or an empty remove finishes without leaving idle.
// busy drops with done, so the next transaction may start in the done cycle.
// Reset empties the heap; contents stay. The receiver cannot stall results.
module binary_max_heap_queue #(
    parameter int CAPACITY = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               action,
    input  logic signed [31:0] value,
    output logic               done,
    output logic [1:0]         status,
    output logic signed [31:0] removed_value,
    output logic [5:0]         entry_count
);
    import bmhq_pkg::*;

    bmhq_cmd_t   cmd;
    bmhq_flags_t flags;

    // Sequencer
    bmhq_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .action (action),
        .flags  (flags),
        .cmd    (cmd),
        .busy   (busy)
    );

    // Heap storage and arithmetic
    bmhq_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .value         (value),
        .cmd           (cmd),
        .flags         (flags),
        .done          (done),
        .status        (status),
        .removed_value (removed_value),
        .entry_count   (entry_count)
    );

endmodule
